// ===== rtl/core/eputc_pkg.sv =====
// ----------------------------------------------------------------------------
// eputc_pkg
// Shared types, constants and calendar helpers for the seconds-to-date core.
// ----------------------------------------------------------------------------
package eputc_pkg;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned BASE_YEAR     = 1970;

  // power-of-two factors split off the divisors before the odd division
  localparam int unsigned DAY_DIV_SH  = 7;
  localparam int unsigned HOUR_DIV_SH = 4;
  localparam int unsigned MIN_DIV_SH  = 2;

  localparam logic [9:0] DAY_DIVISOR  = 10'(SECS_PER_DAY >> DAY_DIV_SH);
  localparam logic [9:0] YEAR_DIVISOR = 10'(DAYS_PER_YEAR);
  localparam logic [9:0] HOUR_DIVISOR = 10'(SECS_PER_HOUR >> HOUR_DIV_SH);
  localparam logic [9:0] MIN_DIVISOR  = 10'(SECS_PER_MIN >> MIN_DIV_SH);

  // reciprocal scaling, chosen so the estimate is short by at most one
  localparam int unsigned DAY_RECIP_SH  = 34;
  localparam int unsigned YEAR_RECIP_SH = 24;
  localparam int unsigned HOUR_RECIP_SH = 20;
  localparam int unsigned MIN_RECIP_SH  = 16;

  localparam logic [24:0] DAY_RECIP  = 25'((64'd1 << DAY_RECIP_SH) / 64'(DAY_DIVISOR));
  localparam logic [24:0] YEAR_RECIP = 25'((64'd1 << YEAR_RECIP_SH) / 64'(YEAR_DIVISOR));
  localparam logic [24:0] HOUR_RECIP = 25'((64'd1 << HOUR_RECIP_SH) / 64'(HOUR_DIVISOR));
  localparam logic [24:0] MIN_RECIP  = 25'((64'd1 << MIN_RECIP_SH) / 64'(MIN_DIVISOR));

  // years since base from which 2100 falls inside the counted span
  localparam logic [7:0]  YEAR_OFS_2100 = 8'd131;
  localparam logic [11:0] YEAR_2100     = 12'd2100;
  localparam logic [3:0]  MONTH_DEC     = 4'd11;
  localparam logic [3:0]  MONTH_FEB     = 4'd1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_BACK,
    OP_CORR,
    OP_SPLIT,
    OP_YEAR,
    OP_FIX,
    OP_MONTH,
    OP_HOUR,
    OP_PUBLISH
  } dp_op_e;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_YEAR,
    DIV_HOUR,
    DIV_MIN
  } dp_div_e;

  typedef struct packed {
    dp_op_e  op;
    dp_div_e div;
  } dp_cmd_t;

  typedef struct packed {
    logic month_done;
  } dp_status_t;

  // only 2000 and 2100 are century years in range 1969..2106
  function automatic logic is_leap(input logic [11:0] year);
    is_leap = (year[1:0] == 2'b00) && (year != YEAR_2100);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    case (month)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: month_days = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   month_days = 5'd30;
      MONTH_FEB:                                 month_days = leap ? 5'd29 : 5'd28;
      default:                                   month_days = 5'd31;
    endcase
  endfunction

endpackage

// ===== rtl/core/eputc_dp.sv =====
// ----------------------------------------------------------------------------
// eputc_dp
// Datapath: divisions by constants through one shared reciprocal multiplier,
// year and month stepping, output registers.
// ----------------------------------------------------------------------------
module eputc_dp (
  input  logic                  clk_i,
  input  eputc_pkg::dp_cmd_t    cmd_i,
  output eputc_pkg::dp_status_t status_o,
  input  logic [31:0]           epoch_seconds_i,
  output logic [11:0]           cal_year_o,
  output logic [3:0]            cal_month_o,
  output logic [4:0]            cal_day_o,
  output logic [4:0]            cal_hour_o,
  output logic [5:0]            cal_minute_o,
  output logic [5:0]            cal_second_o
);

  logic [24:0] num_q, num_d;
  logic [15:0] quo_q, quo_d;
  logic [10:0] rem_q, rem_d;
  logic [16:0] secs_q, secs_d;
  logic [11:0] year_q, year_d;
  logic [9:0]  day_q, day_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  hour_q, hour_d;

  logic [11:0] out_year_q, out_year_d;
  logic [3:0]  out_month_q, out_month_d;
  logic [4:0]  out_day_q, out_day_d;
  logic [4:0]  out_hour_q, out_hour_d;
  logic [5:0]  out_minute_q, out_minute_d;
  logic [5:0]  out_second_q, out_second_d;

  logic [24:0] recip;
  logic [9:0]  divisor;
  logic [24:0] mul_a;
  logic [24:0] mul_b;
  logic [49:0] prod;
  logic [15:0] quo_est;
  logic [24:0] back_diff;
  logic [8:0]  n_plus1;
  logic [6:0]  leap_cnt;
  logic [11:0] year_prev;
  logic [9:0]  month_next;
  logic        month_done;

  always_comb begin
    case (cmd_i.div)
      eputc_pkg::DIV_DAY: begin
        recip   = eputc_pkg::DAY_RECIP;
        divisor = eputc_pkg::DAY_DIVISOR;
      end
      eputc_pkg::DIV_YEAR: begin
        recip   = eputc_pkg::YEAR_RECIP;
        divisor = eputc_pkg::YEAR_DIVISOR;
      end
      eputc_pkg::DIV_HOUR: begin
        recip   = eputc_pkg::HOUR_RECIP;
        divisor = eputc_pkg::HOUR_DIVISOR;
      end
      eputc_pkg::DIV_MIN: begin
        recip   = eputc_pkg::MIN_RECIP;
        divisor = eputc_pkg::MIN_DIVISOR;
      end
      default: begin
        recip   = eputc_pkg::DAY_RECIP;
        divisor = eputc_pkg::DAY_DIVISOR;
      end
    endcase
  end

  // one multiplier: reciprocal estimate first, then quotient times divisor
  assign mul_a     = (cmd_i.op == eputc_pkg::OP_BACK) ? {9'b0, quo_q} : num_q;
  assign mul_b     = (cmd_i.op == eputc_pkg::OP_BACK) ? {15'b0, divisor} : recip;
  assign prod      = {25'b0, mul_a} * {25'b0, mul_b};
  assign back_diff = num_q - prod[24:0];

  always_comb begin
    case (cmd_i.div)
      eputc_pkg::DIV_DAY:  quo_est = prod[eputc_pkg::DAY_RECIP_SH +: 16];
      eputc_pkg::DIV_YEAR: quo_est = prod[eputc_pkg::YEAR_RECIP_SH +: 16];
      eputc_pkg::DIV_HOUR: quo_est = prod[eputc_pkg::HOUR_RECIP_SH +: 16];
      eputc_pkg::DIV_MIN:  quo_est = prod[eputc_pkg::MIN_RECIP_SH +: 16];
      default:             quo_est = prod[eputc_pkg::DAY_RECIP_SH +: 16];
    endcase
  end

  assign n_plus1    = {1'b0, quo_q[7:0]} + 9'd1;
  assign leap_cnt   = n_plus1[8:2] - {6'b0, (quo_q[7:0] >= eputc_pkg::YEAR_OFS_2100)};
  assign year_prev  = year_q - 12'd1;
  assign month_next = day_q - {5'b0, eputc_pkg::month_days(month_q,
                                                             eputc_pkg::is_leap(year_q))};
  assign month_done = month_next[9] || (month_q == eputc_pkg::MONTH_DEC);

  assign status_o.month_done = month_done;

  always_comb begin
    num_d        = num_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    secs_d       = secs_q;
    year_d       = year_q;
    day_d        = day_q;
    month_d      = month_q;
    hour_d       = hour_q;
    out_year_d   = out_year_q;
    out_month_d  = out_month_q;
    out_day_d    = out_day_q;
    out_hour_d   = out_hour_q;
    out_minute_d = out_minute_q;
    out_second_d = out_second_q;
    case (cmd_i.op)
      eputc_pkg::OP_LOAD: begin
        num_d  = epoch_seconds_i[31:7];
        secs_d = {10'b0, epoch_seconds_i[6:0]};
      end
      eputc_pkg::OP_MUL: begin
        quo_d = quo_est;
      end
      eputc_pkg::OP_BACK: begin
        rem_d = back_diff[10:0];
      end
      eputc_pkg::OP_CORR: begin
        if (rem_q >= {1'b0, divisor}) begin
          rem_d = rem_q - {1'b0, divisor};
          quo_d = quo_q + 16'd1;
        end
      end
      eputc_pkg::OP_SPLIT: begin
        secs_d = {rem_q[9:0], secs_q[6:0]};
        num_d  = {9'b0, quo_q};
      end
      eputc_pkg::OP_YEAR: begin
        year_d = 12'(eputc_pkg::BASE_YEAR) + {4'b0, quo_q[7:0]};
        day_d  = {1'b0, rem_q[8:0]} - {3'b0, leap_cnt};
        num_d  = {12'b0, secs_q[16:4]};
      end
      eputc_pkg::OP_FIX: begin
        month_d = '0;
        if (day_q[9]) begin
          year_d = year_prev;
          day_d  = day_q + 10'(eputc_pkg::DAYS_PER_YEAR)
                 + {9'b0, eputc_pkg::is_leap(year_prev)};
        end
      end
      eputc_pkg::OP_MONTH: begin
        if (!month_done) begin
          day_d   = month_next;
          month_d = month_q + 4'd1;
        end
      end
      eputc_pkg::OP_HOUR: begin
        hour_d = quo_q[4:0];
        num_d  = {15'b0, rem_q[7:0], secs_q[3:2]};
      end
      eputc_pkg::OP_PUBLISH: begin
        out_year_d   = year_q;
        out_month_d  = month_q + 4'd1;
        out_day_d    = day_q[4:0] + 5'd1;
        out_hour_d   = hour_q;
        out_minute_d = quo_q[5:0];
        out_second_d = {rem_q[3:0], secs_q[1:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    num_q        <= num_d;
    quo_q        <= quo_d;
    rem_q        <= rem_d;
    secs_q       <= secs_d;
    year_q       <= year_d;
    day_q        <= day_d;
    month_q      <= month_d;
    hour_q       <= hour_d;
    out_year_q   <= out_year_d;
    out_month_q  <= out_month_d;
    out_day_q    <= out_day_d;
    out_hour_q   <= out_hour_d;
    out_minute_q <= out_minute_d;
    out_second_q <= out_second_d;
  end

  assign cal_year_o   = out_year_q;
  assign cal_month_o  = out_month_q;
  assign cal_day_o    = out_day_q;
  assign cal_hour_o   = out_hour_q;
  assign cal_minute_o = out_minute_q;
  assign cal_second_o = out_second_q;

endmodule

// ===== rtl/core/eputc_ctrl.sv =====
// ----------------------------------------------------------------------------
// eputc_ctrl
// Controller: sequences the divisions, year correction and month walk, and
// runs the input and output handshakes.
// ----------------------------------------------------------------------------
module eputc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output eputc_pkg::dp_cmd_t    cmd_o,
  input  eputc_pkg::dp_status_t status_i
);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_MUL     = 10'b00_0000_0010,
    ST_BACK    = 10'b00_0000_0100,
    ST_CORR    = 10'b00_0000_1000,
    ST_SPLIT   = 10'b00_0001_0000,
    ST_YEAR    = 10'b00_0010_0000,
    ST_FIX     = 10'b00_0100_0000,
    ST_MONTH   = 10'b00_1000_0000,
    ST_HOUR    = 10'b01_0000_0000,
    ST_PUBLISH = 10'b10_0000_0000
  } state_e;

  state_e              state_q, state_d;
  eputc_pkg::dp_div_e  div_q, div_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;
  logic                publish;

  assign out_free = !out_valid_q || !out_stall_i;
  assign publish  = (state_q == ST_PUBLISH) && out_free;

  always_comb begin
    state_d   = state_q;
    div_d     = div_q;
    cmd_o.op  = eputc_pkg::OP_NONE;
    cmd_o.div = div_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = eputc_pkg::OP_LOAD;
          div_d    = eputc_pkg::DIV_DAY;
          state_d  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.op = eputc_pkg::OP_MUL;
        state_d  = ST_BACK;
      end
      ST_BACK: begin
        cmd_o.op = eputc_pkg::OP_BACK;
        state_d  = ST_CORR;
      end
      ST_CORR: begin
        cmd_o.op = eputc_pkg::OP_CORR;
        case (div_q)
          eputc_pkg::DIV_DAY:  state_d = ST_SPLIT;
          eputc_pkg::DIV_YEAR: state_d = ST_YEAR;
          eputc_pkg::DIV_HOUR: state_d = ST_HOUR;
          eputc_pkg::DIV_MIN:  state_d = ST_PUBLISH;
          default:             state_d = ST_IDLE;
        endcase
      end
      ST_SPLIT: begin
        cmd_o.op = eputc_pkg::OP_SPLIT;
        div_d    = eputc_pkg::DIV_YEAR;
        state_d  = ST_MUL;
      end
      ST_YEAR: begin
        cmd_o.op = eputc_pkg::OP_YEAR;
        state_d  = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.op = eputc_pkg::OP_FIX;
        state_d  = ST_MONTH;
      end
      ST_MONTH: begin
        cmd_o.op = eputc_pkg::OP_MONTH;
        if (status_i.month_done) begin
          div_d   = eputc_pkg::DIV_HOUR;
          state_d = ST_MUL;
        end
      end
      ST_HOUR: begin
        cmd_o.op = eputc_pkg::OP_HOUR;
        div_d    = eputc_pkg::DIV_MIN;
        state_d  = ST_MUL;
      end
      ST_PUBLISH: begin
        if (out_free) begin
          cmd_o.op = eputc_pkg::OP_PUBLISH;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (publish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_q       <= eputc_pkg::DIV_DAY;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_q       <= div_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/epoch_seconds_to_utc_date_core.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_date_core
// Unix seconds to Gregorian UTC date and time of day.
// ----------------------------------------------------------------------------
// One item is converted at a time. The conversion runs four divisions by
// constants (days, years, hours, minutes), each a reciprocal multiply, a
// multiply back and one correction step on a single shared 25 by 25 bit
// multiplier, with year correction and a month walk that steps one month
// at a time between the year and hour divisions, then the hand-over. A new
// item is accepted once the result has moved into the output register,
// even while that result is still stalled. No state is kept between items.
module epoch_seconds_to_utc_date_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] epoch_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] cal_year_o,
  output logic [3:0]  cal_month_o,
  output logic [4:0]  cal_day_o,
  output logic [4:0]  cal_hour_o,
  output logic [5:0]  cal_minute_o,
  output logic [5:0]  cal_second_o
);

  eputc_pkg::dp_cmd_t    cmd;
  eputc_pkg::dp_status_t status;

  eputc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  eputc_dp u_dp (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .epoch_seconds_i (epoch_seconds_i),
    .cal_year_o      (cal_year_o),
    .cal_month_o     (cal_month_o),
    .cal_day_o       (cal_day_o),
    .cal_hour_o      (cal_hour_o),
    .cal_minute_o    (cal_minute_o),
    .cal_second_o    (cal_second_o)
  );

endmodule

// ===== rtl/core/eputc_checker.sv =====
// ----------------------------------------------------------------------------
// eputc_checker
// Port-level checks on the seconds-to-date core, bound to the top level.
// ----------------------------------------------------------------------------
module eputc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [31:0] epoch_seconds_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [11:0] cal_year_o,
  input logic [3:0]  cal_month_o,
  input logic [4:0]  cal_day_o,
  input logic [4:0]  cal_hour_o,
  input logic [5:0]  cal_minute_o,
  input logic [5:0]  cal_second_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an accepted item keeps the input busy while it is converted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not busy after accepting an item");

  // no result can appear on the cycle right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

  // offered date and time fields lie in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cal_month_o >= 4'd1) && (cal_month_o <= 4'd12)
                 && (cal_day_o >= 5'd1) && (cal_hour_o <= 5'd23)
                 && (cal_minute_o <= 6'd59) && (cal_second_o <= 6'd59)
                 && (cal_year_o >= 12'd1970) && (cal_year_o <= 12'd2106))
    else $error("result field out of range");

endmodule

bind epoch_seconds_to_utc_date_core eputc_checker u_checker (.*);
